### rtl/spw_pkg.sv
// Shared types and constants for the sliding prefetch window.
package spw_pkg;

  localparam int REG_BITS = 13;

  typedef enum logic [1:0] {
    OP_SCROLL = 2'd0,
    OP_RESET  = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef enum logic {
    CFG_BUFFER_SIZE     = 1'b0,
    CFG_SHIFT_THRESHOLD = 1'b1
  } cfg_idx_t;

  localparam logic [REG_BITS-1:0] BUFFER_SIZE_RST     = 13'd64;
  localparam logic [REG_BITS-1:0] SHIFT_THRESHOLD_RST = 13'd8;

endpackage

### rtl/sliding_prefetch_window.sv
// Sliding prefetch window: scroll, re-center and tick handling with range reporting.
//
// One word is accepted per cycle while in_stall is low and gives one result word:
// the input register captures the word, then the state update applies it to the
// window state and the result register captures the result. The input register
// can take one new word while a stalled result waits. Window start, release and
// fetch indices are INDEX_BITS wide. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while the block is idle; this is not enforced.
module sliding_prefetch_window #(
  parameter int INDEX_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [spw_pkg::REG_BITS-1:0]  cfg_data,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_operation,
  input  logic [INDEX_BITS-1:0]         in_position,
  input  logic [INDEX_BITS-1:0]         in_new_total,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [INDEX_BITS-1:0]         out_window_first,
  output logic                          out_release_valid,
  output logic [INDEX_BITS-1:0]         out_release_first,
  output logic [INDEX_BITS-1:0]         out_release_last,
  output logic                          out_fetch_valid,
  output logic [INDEX_BITS-1:0]         out_fetch_first,
  output logic [INDEX_BITS-1:0]         out_fetch_last
);

  localparam int RB = spw_pkg::REG_BITS;
  localparam int MB = (INDEX_BITS > RB) ? INDEX_BITS : RB;
  localparam int SW = MB + 3;

  typedef logic signed [SW-1:0] sval_t;

  // configuration
  logic [RB-1:0] buf_size_r;
  logic [RB-1:0] thresh_r;

  // input stage
  logic                  in_vld_r;
  logic [1:0]            op_r;
  logic [INDEX_BITS-1:0] pos_r;
  logic [INDEX_BITS-1:0] ntot_r;

  // window state
  logic [INDEX_BITS-1:0] win_start_r, win_start_nxt;
  logic [INDEX_BITS-1:0] item_total_r, item_total_nxt;
  sval_t                 pend_r, pend_nxt;
  sval_t                 fetch_start_r, fetch_start_nxt;
  sval_t                 drop_start_r, drop_start_nxt;
  logic [RB-1:0]         fetch_cnt_r, fetch_cnt_nxt;
  logic [RB-1:0]         drop_cnt_r, drop_cnt_nxt;
  logic                  rc_pend_r, rc_pend_nxt;
  logic                  armed_r, armed_nxt;

  // result stage
  logic                  out_vld_r;
  logic                  rel_vld_nxt, fet_vld_nxt;
  logic [INDEX_BITS-1:0] rel_first_nxt, rel_last_nxt, fet_first_nxt, fet_last_nxt;
  logic [INDEX_BITS-1:0] win_first_r;
  logic                  rel_vld_r, fet_vld_r;
  logic [INDEX_BITS-1:0] rel_first_r, rel_last_r, fet_first_r, fet_last_r;

  logic advance;

  // datapath temporaries
  sval_t bs_s, half_s, thr_s, ws_s, tot_s, pos_s, ntot_s;
  sval_t p, d, nd, rc_ws, ds, fs, d_end, f_end;
  logic  clamped, do_rc;

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  assign bs_s   = sval_t'({{(SW-RB){1'b0}}, buf_size_r});
  assign half_s = bs_s >>> 1;
  assign thr_s  = sval_t'({{(SW-RB){1'b0}}, thresh_r});
  assign ws_s   = sval_t'({{(SW-INDEX_BITS){1'b0}}, win_start_r});
  assign tot_s  = sval_t'({{(SW-INDEX_BITS){1'b0}}, item_total_r});
  assign pos_s  = sval_t'({{(SW-INDEX_BITS){1'b0}}, pos_r});
  assign ntot_s = sval_t'({{(SW-INDEX_BITS){1'b0}}, ntot_r});

  always_comb begin
    win_start_nxt   = win_start_r;
    item_total_nxt  = item_total_r;
    pend_nxt        = pend_r;
    fetch_start_nxt = fetch_start_r;
    drop_start_nxt  = drop_start_r;
    fetch_cnt_nxt   = fetch_cnt_r;
    drop_cnt_nxt    = drop_cnt_r;
    rc_pend_nxt     = rc_pend_r;
    armed_nxt       = armed_r;
    rel_vld_nxt     = 1'b0;
    fet_vld_nxt     = 1'b0;
    rel_first_nxt   = '0;
    rel_last_nxt    = '0;
    fet_first_nxt   = '0;
    fet_last_nxt    = '0;
    p       = '0;
    d       = '0;
    nd      = '0;
    rc_ws   = '0;
    ds      = drop_start_r;
    fs      = fetch_start_r;
    d_end   = '0;
    f_end   = '0;
    clamped = 1'b0;
    do_rc   = 1'b0;

    case (op_r)
      spw_pkg::OP_SCROLL: begin
        if (tot_s > bs_s) begin
          p = pos_s - half_s;
          if (p < 0) begin
            p       = '0;
            clamped = 1'b1;
          end else if (p > tot_s - bs_s) begin
            p       = tot_s - bs_s;
            clamped = 1'b1;
          end
          d        = ws_s - p;
          nd       = -d;
          pend_nxt = d;
          if (d >= bs_s || nd >= bs_s || rc_pend_r) begin
            do_rc = 1'b1;
            rc_ws = p;
          end else if (d >= thr_s || (clamped && d > 0)) begin
            fetch_cnt_nxt = d[RB-1:0];
            drop_cnt_nxt  = d[RB-1:0];
            armed_nxt     = 1'b1;
          end else if (nd >= thr_s || (clamped && nd > 0)) begin
            fetch_cnt_nxt = nd[RB-1:0];
            drop_cnt_nxt  = nd[RB-1:0];
            armed_nxt     = 1'b1;
          end
        end
      end
      spw_pkg::OP_RESET: begin
        do_rc          = 1'b1;
        item_total_nxt = ntot_r;
        rc_ws          = pos_s - half_s;
        if (rc_ws + bs_s > ntot_s - sval_t'(1)) rc_ws = ntot_s - bs_s;
        if (rc_ws < 0) rc_ws = '0;
      end
      spw_pkg::OP_TICK: begin
        if (armed_r) begin
          if (rc_pend_r) begin
            rc_pend_nxt = 1'b0;
          end else if (pend_r < 0) begin
            ds = ws_s;
            fs = ws_s + bs_s;
          end else if (pend_r > 0) begin
            ds = ws_s + bs_s - pend_r;
            fs = ws_s - pend_r;
          end
          drop_start_nxt  = ds;
          fetch_start_nxt = fs;

          d_end = ds + sval_t'({{(SW-RB){1'b0}}, drop_cnt_r});
          if (d_end > tot_s) d_end = tot_s;
          d_end = d_end - sval_t'(1);
          if (d_end >= ds) begin
            rel_vld_nxt   = 1'b1;
            rel_first_nxt = ds[INDEX_BITS-1:0];
            rel_last_nxt  = d_end[INDEX_BITS-1:0];
          end

          f_end = fs + sval_t'({{(SW-RB){1'b0}}, fetch_cnt_r});
          if (f_end > tot_s) f_end = tot_s;
          f_end = f_end - sval_t'(1);
          if (f_end >= fs) begin
            fet_vld_nxt   = 1'b1;
            fet_first_nxt = fs[INDEX_BITS-1:0];
            fet_last_nxt  = f_end[INDEX_BITS-1:0];
          end

          drop_cnt_nxt  = '0;
          fetch_cnt_nxt = '0;
          win_start_nxt = INDEX_BITS'(ws_s - pend_r);
          pend_nxt      = '0;
          armed_nxt     = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (do_rc) begin
      if (!rc_pend_r) begin
        drop_start_nxt = ws_s;
        drop_cnt_nxt   = buf_size_r;
      end
      win_start_nxt   = rc_ws[INDEX_BITS-1:0];
      pend_nxt        = '0;
      fetch_start_nxt = rc_ws;
      fetch_cnt_nxt   = buf_size_r;
      rc_pend_nxt     = 1'b1;
      armed_nxt       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= spw_pkg::BUFFER_SIZE_RST;
      thresh_r   <= spw_pkg::SHIFT_THRESHOLD_RST;
    end else if (cfg_we) begin
      if (cfg_index == spw_pkg::CFG_BUFFER_SIZE) buf_size_r <= cfg_data;
      else thresh_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r   <= in_operation;
      pos_r  <= in_position;
      ntot_r <= in_new_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r   <= '0;
      item_total_r  <= '0;
      pend_r        <= '0;
      fetch_start_r <= '0;
      drop_start_r  <= '0;
      fetch_cnt_r   <= '0;
      drop_cnt_r    <= '0;
      rc_pend_r     <= 1'b1;
      armed_r       <= 1'b0;
    end else if (advance) begin
      win_start_r   <= win_start_nxt;
      item_total_r  <= item_total_nxt;
      pend_r        <= pend_nxt;
      fetch_start_r <= fetch_start_nxt;
      drop_start_r  <= drop_start_nxt;
      fetch_cnt_r   <= fetch_cnt_nxt;
      drop_cnt_r    <= drop_cnt_nxt;
      rc_pend_r     <= rc_pend_nxt;
      armed_r       <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      win_first_r <= win_start_nxt;
      rel_vld_r   <= rel_vld_nxt;
      rel_first_r <= rel_first_nxt;
      rel_last_r  <= rel_last_nxt;
      fet_vld_r   <= fet_vld_nxt;
      fet_first_r <= fet_first_nxt;
      fet_last_r  <= fet_last_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_window_first  = win_first_r;
  assign out_release_valid = rel_vld_r;
  assign out_release_first = rel_first_r;
  assign out_release_last  = rel_last_r;
  assign out_fetch_valid   = fet_vld_r;
  assign out_fetch_first   = fet_first_r;
  assign out_fetch_last    = fet_last_r;

endmodule
